/* src/expiring_address_deny_list_top_defines.svh */
// Assertion macros shared by the deny-list RTL.
// No dependencies; define ASSERT_OFF to drop all checks.
`ifndef EXPIRING_ADDRESS_DENY_LIST_TOP_DEFINES_SVH
`define EXPIRING_ADDRESS_DENY_LIST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define EDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deny list assertion failed");
`define EDL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deny list assertion failed");
`else
`define EDL_ASSERT(lbl, prop)
`define EDL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* src/edl_pkg.sv */
// Package for the expiring address deny list: sizes, item types,
// controller states and the command/status bundles. No dependencies.
package edl_pkg;

  localparam int LIST_DEPTH    = 16;
  localparam int ADDRESS_BITS  = 48;
  localparam int IDX_W         = $clog2(LIST_DEPTH);
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int DEADLINE_W    = 32;
  localparam int DEV_ADDR_W    = 48;
  localparam int TIMEOUT_W     = 31;
  localparam int ENTRY_COUNT_W = 5;

  typedef struct packed {
    logic                  operation;
    logic [DEV_ADDR_W-1:0] device_address;
    logic [DEADLINE_W-1:0] now_ms;
    logic [TIMEOUT_W-1:0]  deny_ms;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] addr;
    logic [DEADLINE_W-1:0]   deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SEARCH  = 5'b00010,
    ST_COMPACT = 5'b00100,
    ST_APPEND  = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic compact;
    logic rewind;
    logic append;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic op_add;
  } status_t;

endpackage

/* src/expiring_address_deny_list_top.sv */
// One item in flight: the next is accepted only once the result is registered, and a
// result held back by the receiver stalls acceptance of the next item.
// Synchronous active-low reset empties the list; entry storage itself is not cleared.
// Top level: ties together edl_ctrl and edl_datapath; depends on edl_pkg.
module expiring_address_deny_list_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  edl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output edl_pkg::out_item_t out_data
);

  edl_pkg::cmd_t    cmd;
  edl_pkg::status_t status;

  edl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  edl_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .out_data(out_data)
  );

endmodule

/* src/edl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module edl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/edl_ctrl.sv */
// Sequencing state machine for the deny list: handshakes and walk passes.
// Depends on edl_pkg and the assertion macro header.
`include "expiring_address_deny_list_top_defines.svh"
module edl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  edl_pkg::status_t status,
  output edl_pkg::cmd_t    cmd
);

  edl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      edl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == edl_pkg::OP_ADD) ? edl_pkg::ST_SEARCH : edl_pkg::ST_COMPACT;
        end
      end
      edl_pkg::ST_SEARCH: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          cmd.rewind = 1'b1;
          state_nxt  = edl_pkg::ST_COMPACT;
        end
      end
      edl_pkg::ST_COMPACT: begin
        cmd.walk    = 1'b1;
        cmd.compact = 1'b1;
        if (status.walk_done) begin
          state_nxt = status.op_add ? edl_pkg::ST_APPEND : edl_pkg::ST_FINISH;
        end
      end
      edl_pkg::ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = edl_pkg::ST_FINISH;
      end
      edl_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = edl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = edl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `EDL_ASSERT(a_accept_leaves_idle, in_valid && in_ready |=> state_r != edl_pkg::ST_IDLE)
  `EDL_ASSERT(a_publish_no_overwrite, cmd.publish |-> !out_valid_r || out_ready)
  `EDL_ASSERT_ALWAYS(a_ready_only_idle, in_ready |-> state_r == edl_pkg::ST_IDLE)

endmodule

/* src/edl_datapath.sv */
// Deny-list datapath: item registers, entry RAM walk, compaction and append.
// Depends on edl_pkg, edl_ram and the assertion macro header.
`include "expiring_address_deny_list_top_defines.svh"
module edl_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  edl_pkg::in_item_t  in_data,
  input  edl_pkg::cmd_t      cmd,
  output edl_pkg::status_t   status,
  output edl_pkg::out_item_t out_data
);

  logic                             op_r, op_nxt;
  logic [edl_pkg::ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [edl_pkg::DEADLINE_W-1:0]   now_r, now_nxt;
  logic [edl_pkg::TIMEOUT_W-1:0]    timeout_r, timeout_nxt;
  logic [edl_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [edl_pkg::CNT_W-1:0]        rd_r, rd_nxt;
  logic [edl_pkg::CNT_W-1:0]        wr_r, wr_nxt;
  logic [edl_pkg::CNT_W-1:0]        idx_r;
  logic                             pend_r;
  logic                             hit_r, hit_nxt;
  logic                             dropped_r, dropped_nxt;
  logic                             full_r, full_nxt;
  edl_pkg::out_item_t               out_r, out_nxt;

  logic                             issue;
  logic                             match;
  logic                             expired;
  logic                             drop;
  logic                             keep_wr;
  logic [edl_pkg::DEADLINE_W-1:0]   diff;
  logic                             we;
  edl_pkg::entry_t                  wdata;
  edl_pkg::entry_t                  rdata;
  logic [edl_pkg::ENTRY_W-1:0]      rdata_raw;

  assign issue   = cmd.walk && (rd_r != count_r);
  assign rdata   = edl_pkg::entry_t'(rdata_raw);
  assign match   = (rdata.addr == addr_r);
  assign diff    = rdata.deadline - now_r;
  assign expired = diff[edl_pkg::DEADLINE_W-1];

  always_comb begin
    if (op_r == edl_pkg::OP_ADD) begin
      drop = (hit_r && match && !dropped_r) || (!hit_r && full_r && (idx_r == '0));
    end else begin
      drop = expired;
    end
  end

  assign keep_wr = cmd.walk && cmd.compact && pend_r && !drop;
  assign we      = keep_wr || cmd.append;

  always_comb begin
    if (cmd.append) begin
      wdata.addr     = addr_r;
      wdata.deadline = now_r + {1'b0, timeout_r};
    end else begin
      wdata = rdata;
    end
  end

  always_comb begin
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    now_nxt     = now_r;
    timeout_nxt = timeout_r;
    count_nxt   = count_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    hit_nxt     = hit_r;
    dropped_nxt = dropped_r;
    full_nxt    = full_r;
    out_nxt     = out_r;
    if (cmd.load) begin
      op_nxt      = in_data.operation;
      addr_nxt    = edl_pkg::ADDRESS_BITS'(in_data.device_address);
      now_nxt     = in_data.now_ms;
      timeout_nxt = in_data.deny_ms;
      rd_nxt      = '0;
      wr_nxt      = '0;
      hit_nxt     = 1'b0;
      dropped_nxt = 1'b0;
      full_nxt    = (count_r == edl_pkg::CNT_W'(edl_pkg::LIST_DEPTH));
    end
    if (cmd.rewind) begin
      rd_nxt = '0;
    end else if (issue) begin
      rd_nxt = rd_r + 1'b1;
    end
    if (cmd.walk && pend_r) begin
      if (!cmd.compact) begin
        if (match) begin
          hit_nxt = 1'b1;
        end
      end else if (drop) begin
        dropped_nxt = 1'b1;
      end else begin
        wr_nxt = wr_r + 1'b1;
        if (op_r == edl_pkg::OP_CHECK && match) begin
          hit_nxt = 1'b1;
        end
      end
    end
    if (cmd.append) begin
      wr_nxt = wr_r + 1'b1;
    end
    if (cmd.publish) begin
      count_nxt           = wr_r;
      out_nxt.hit         = hit_r;
      out_nxt.entry_count = edl_pkg::ENTRY_COUNT_W'(wr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= issue;
    end
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    now_r     <= now_nxt;
    timeout_r <= timeout_nxt;
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    idx_r     <= rd_r;
    hit_r     <= hit_nxt;
    dropped_r <= dropped_nxt;
    full_r    <= full_nxt;
    out_r     <= out_nxt;
  end

  edl_ram #(
    .WIDTH(edl_pkg::ENTRY_W),
    .DEPTH(edl_pkg::LIST_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wr_r[edl_pkg::IDX_W-1:0]),
    .wdata(wdata),
    .re   (issue),
    .raddr(rd_r[edl_pkg::IDX_W-1:0]),
    .rdata(rdata_raw)
  );

  assign status.walk_done = (rd_r == count_r) && !pend_r;
  assign status.op_add    = (op_r == edl_pkg::OP_ADD);
  assign out_data         = out_r;

  `EDL_ASSERT(a_compact_behind_read, cmd.walk |-> wr_r <= rd_r)
  `EDL_ASSERT(a_count_in_range, count_r <= edl_pkg::CNT_W'(edl_pkg::LIST_DEPTH))

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for expiring_address_deny_list_top: directed and random
// check/add items against an in-bench model of the deny table, with random idling.
// Depends on edl_pkg and the top-level RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ADDR_POOL     = 24;
  localparam logic [30:0] SHORT_DENY_MS = 31'(10 * 1000);
  localparam logic [30:0] LONG_DENY_MS  = 31'(10 * 60 * 1000);
  localparam logic [43:0] TABLE_FILL    = 44'h1234_5678_9AB;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  edl_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  edl_pkg::out_item_t out_data;

  logic [edl_pkg::ADDRESS_BITS-1:0] listed_addr[edl_pkg::LIST_DEPTH];
  logic [edl_pkg::DEADLINE_W-1:0]   listed_deadline[edl_pkg::LIST_DEPTH];
  int                               listed_count = 0;

  edl_pkg::out_item_t pending_results[$];
  int                 mismatch_count  = 0;
  int                 hold_off_cycles = 0;
  bit                 tx_idle_on      = 1'b1;
  bit                 rx_idle_on      = 1'b1;
  logic [31:0]        wall_ms;

  expiring_address_deny_list_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Table update for one item; returns the result it produces.
  function automatic edl_pkg::out_item_t deny_list_apply(edl_pkg::in_item_t it);
    logic [31:0]        margin;
    int                 wr = 0;
    int                 pos;
    logic               found;
    edl_pkg::out_item_t res;
    if (it.operation == edl_pkg::OP_CHECK) begin
      for (int rd = 0; rd < listed_count; rd++) begin
        margin = listed_deadline[rd] - it.now_ms;
        if (!margin[31]) begin
          listed_addr[wr]     = listed_addr[rd];
          listed_deadline[wr] = listed_deadline[rd];
          wr++;
        end
      end
      listed_count = wr;
    end
    pos = listed_count;
    for (int i = listed_count - 1; i >= 0; i--)
      if (listed_addr[i] == it.device_address) pos = i;
    found = (pos < listed_count);
    if (it.operation == edl_pkg::OP_ADD) begin
      if (!found && listed_count >= edl_pkg::LIST_DEPTH) pos = 0;
      if (pos < listed_count) begin
        for (int i = pos; i + 1 < listed_count; i++) begin
          listed_addr[i]     = listed_addr[i + 1];
          listed_deadline[i] = listed_deadline[i + 1];
        end
        listed_count--;
      end
      if (listed_count < edl_pkg::LIST_DEPTH) begin
        listed_addr[listed_count]     = it.device_address;
        listed_deadline[listed_count] = it.now_ms + {1'b0, it.deny_ms};
        listed_count++;
      end
    end
    res.hit         = found;
    res.entry_count = edl_pkg::ENTRY_COUNT_W'(listed_count);
    return res;
  endfunction

  task automatic send_item(input logic op, input logic [edl_pkg::DEV_ADDR_W-1:0] addr,
                           input logic [31:0] now, input logic [30:0] tmo);
    edl_pkg::in_item_t it;
    int                gap;
    it.operation      = op;
    it.device_address = addr;
    it.now_ms         = now;
    it.deny_ms        = tmo;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(deny_list_apply(it));
  endtask

  initial begin : result_checker
    edl_pkg::out_item_t want;
    int                 stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = rx_idle_on ? $urandom_range(0, 7) : 0;
      stall += hold_off_cycles;
      hold_off_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: hit %0d, entry_count %0d",
               out_data.hit, out_data.entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit mismatch: expected %0d, got %0d", want.hit, out_data.hit);
          mismatch_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, got %0d",
                 want.entry_count, out_data.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Equal deadline stays listed, one ms later it expires; wrapped deadlines,
  // re-adding a listed address, and an add that leaves stale entries alone.
  task automatic test_expiry_edges;
    send_item(edl_pkg::OP_ADD,   48'h0, 32'h0, 31'h0);
    send_item(edl_pkg::OP_CHECK, 48'h0, 32'h0, 31'h7FFF_FFFF);
    send_item(edl_pkg::OP_CHECK, 48'h0, 32'h1, 31'h0);
    send_item(edl_pkg::OP_ADD,   48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(edl_pkg::OP_ADD,   48'h5555_5555_5555, 32'hFFFF_FFF0, 31'h100);
    send_item(edl_pkg::OP_ADD,   48'hFFFF_FFFF_FFFF, 32'hFFFF_FFF8, 31'd10);
    send_item(edl_pkg::OP_CHECK, 48'h5555_5555_5555, 32'h0000_0080, 31'h0);
    send_item(edl_pkg::OP_ADD,   48'hAAAA_AAAA_AAAA, 32'h4000_0000, SHORT_DENY_MS);
    send_item(edl_pkg::OP_CHECK, 48'h1234_5678_9ABC, 32'h4000_0000, 31'h0);
  endtask

  // Overfill the table so the oldest entry is evicted, then re-add on a full table.
  task automatic test_full_table;
    for (int i = 0; i < edl_pkg::LIST_DEPTH; i++)
      send_item(edl_pkg::OP_ADD, {4'(i), TABLE_FILL}, 32'h7000_0000, LONG_DENY_MS);
    send_item(edl_pkg::OP_ADD,   {4'd5, TABLE_FILL}, 32'h7000_0010, SHORT_DENY_MS);
    send_item(edl_pkg::OP_CHECK, 48'hAAAA_AAAA_AAAA, 32'h7000_0020, 31'h0);
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [edl_pkg::DEV_ADDR_W-1:0] pool[ADDR_POOL];
    logic [edl_pkg::DEV_ADDR_W-1:0] addr;
    logic [30:0]                    tmo;
    int                             pick;
    foreach (pool[i]) pool[i] = 48'({$urandom, $urandom});
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      addr = pool[$urandom_range(0, ADDR_POOL - 1)];
      else if (pick < 90) addr = pool[$urandom_range(0, ADDR_POOL - 1)] ^
                                 (48'd1 << $urandom_range(0, 47));
      else                addr = 48'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 3)      wall_ms = $urandom;
      else if (pick < 6) wall_ms = wall_ms - $urandom_range(0, 3000);
      else               wall_ms = wall_ms + $urandom_range(0, 1500);
      pick = $urandom_range(0, 99);
      if (pick < 60)      tmo = 31'($urandom_range(0, 20000));
      else if (pick < 75) tmo = LONG_DENY_MS;
      else if (pick < 85) tmo = SHORT_DENY_MS;
      else if (pick < 92) tmo = 31'h0;
      else                tmo = 31'($urandom);
      send_item(logic'($urandom_range(0, 1)), addr, wall_ms, tmo);
    end
  endtask

  // Receiver stalls for a long stretch while items keep coming back to back.
  task automatic test_output_backpressure;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    tx_idle_on      = 1'b0;
    hold_off_cycles = 400;
    test_random_traffic(24);
    tx_idle_on = 1'b1;
  endtask

  initial begin
    wall_ms = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_expiry_edges();
    test_full_table();
    test_random_traffic(500);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(300);
    rx_idle_on = 1'b1;
    test_output_backpressure();
    test_random_traffic(500);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
